[design/per_group_wait_latency_tracker_core_assert.svh]
// Assertion macros shared by the tracker RTL.
// Needs nothing else; files take it by include.
`ifndef PER_GROUP_WAIT_LATENCY_TRACKER_CORE_ASSERT_SVH
`define PER_GROUP_WAIT_LATENCY_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define WGLT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define WGLT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/wglt_pkg.sv]
// Package for the per-group wait latency tracker.
// Table sizes, entry layouts, command and status codes. No dependencies.
`default_nettype none
package wglt_pkg;
  localparam int START_ENTRIES = 1024;
  localparam int GROUP_ENTRIES = 256;
  localparam int SA_W = $clog2(START_ENTRIES);
  localparam int GA_W = $clog2(GROUP_ENTRIES);

  localparam logic [1:0] CMD_WAKE   = 2'd0;
  localparam logic [1:0] CMD_SWITCH = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    STS_NONE  = 2'd0,
    STS_ACC   = 2'd1,
    STS_GFULL = 2'd2,
    STS_QUERY = 2'd3
  } status_t;

  typedef struct packed {
    logic        vld;
    logic [21:0] pid;
    logic [63:0] creation;
    logic [63:0] stamp;
  } start_entry_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] cnt;
    logic [63:0] tot;
  } group_entry_t;

  localparam int START_W = $bits(start_entry_t);
  localparam int GROUP_W = $bits(group_entry_t);
endpackage
`default_nettype wire

[design/wglt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for both tracker tables.
`default_nettype none
module wglt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/per_group_wait_latency_tracker_core.sv]
// Top level of the per-group wait latency tracker: sequencer, start and group
// compares and a shared 64-bit adder. Uses wglt_pkg, wglt_ram and the assert header.
//
//  channel | ports                                   | handshake
//  input   | in_command .. in_prev_runnable          | start high, busy low
//  result  | out_status .. out_group_total_ns        | out_valid, one cycle
//
// The start table is scanned one entry at a time, a read state and then a check
// state per entry (one RAM read port), the group table likewise. A wakeup scans
// the start table; a switch scans it up to twice and, on a hit, then the group
// table; a query scans the group table. A hit ends a scan early. After reset a
// clearing pass writes every start table entry with busy high. The receiver
// cannot stall; out_valid pulses in the first cycle that busy is low again.
`default_nettype none
module per_group_wait_latency_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [63:0] in_now_ns,
  input  wire logic [21:0] in_task_pid,
  input  wire logic [63:0] in_task_start,
  input  wire logic [63:0] in_task_group,
  input  wire logic [21:0] in_prev_pid,
  input  wire logic [63:0] in_prev_start,
  input  wire logic        in_prev_runnable,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_insert_dropped,
  output logic [63:0]      out_latency_ns,
  output logic [63:0]      out_group_count,
  output logic [63:0]      out_group_total_ns
);
  import wglt_pkg::*;
  `include "per_group_wait_latency_tracker_core_assert.svh"

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SCK, S_SWR, S_LAT,
    S_GRD, S_GCK, S_GCNT, S_GTOT, S_OUT
  } state_t;

  state_t state_r;

  logic [1:0]  cmd_r;
  logic [63:0] now_r, group_r, tpid_start_r, stamp_r;
  logic [21:0] tpid_r, key_pid_r;
  logic [63:0] key_start_r;
  logic        find_phase_r, find_after_r;

  logic [SA_W-1:0] s_idx_r, s_hit_idx_r, s_free_idx_r;
  logic            s_hit_r, s_free_found_r;
  logic [GA_W-1:0] g_idx_r, g_free_idx_r, g_sel_r;
  logic            g_free_found_r;
  logic [GROUP_ENTRIES-1:0] g_valid_r;

  status_t     status_r;
  logic        dropped_r, out_valid_r;
  logic [63:0] lat_r, cnt_r, tot_r;

  // Start table RAM.
  logic               s_we;
  logic [SA_W-1:0]    s_waddr;
  logic [START_W-1:0] s_wdata, s_rdata;
  start_entry_t       s_ent, s_wr_ent;

  // Group table RAM.
  logic               g_we;
  logic [GROUP_W-1:0] g_rdata;
  group_entry_t       g_ent, g_wr_ent;

  // Shared adder.
  logic [63:0] add_a, add_b, add_sum;
  logic        add_ci;

  logic s_match, g_match, s_last, g_last;

  wglt_ram #(.WIDTH(START_W), .DEPTH(START_ENTRIES)) u_start_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_idx_r), .rdata(s_rdata)
  );

  wglt_ram #(.WIDTH(GROUP_W), .DEPTH(GROUP_ENTRIES)) u_group_ram (
    .clk(clk), .we(g_we), .waddr(g_sel_r), .wdata(g_wr_ent),
    .raddr(g_idx_r), .rdata(g_rdata)
  );

  assign s_ent   = start_entry_t'(s_rdata);
  assign g_ent   = group_entry_t'(g_rdata);
  assign s_match = s_ent.vld && (s_ent.pid == key_pid_r) && (s_ent.creation == key_start_r);
  assign g_match = g_valid_r[g_idx_r] && (g_ent.id == group_r);
  assign s_last  = (s_idx_r == SA_W'(START_ENTRIES - 1));
  assign g_last  = (g_idx_r == GA_W'(GROUP_ENTRIES - 1));

  always_comb begin
    s_we     = 1'b0;
    s_waddr  = s_idx_r;
    s_wr_ent = '0;
    case (state_r)
      S_CLR: s_we = 1'b1;
      S_SWR: begin
        s_we     = s_hit_r || s_free_found_r;
        s_waddr  = s_hit_r ? s_hit_idx_r : s_free_idx_r;
        s_wr_ent = '{vld: 1'b1, pid: key_pid_r, creation: key_start_r, stamp: now_r};
      end
      S_LAT: begin
        s_we    = 1'b1;
        s_waddr = s_hit_idx_r;
      end
      default: s_we = 1'b0;
    endcase
  end
  assign s_wdata = s_wr_ent;

  always_comb begin
    add_a  = cnt_r;
    add_b  = 64'd1;
    add_ci = 1'b0;
    case (state_r)
      S_LAT: begin
        add_a  = now_r;
        add_b  = ~stamp_r;
        add_ci = 1'b1;
      end
      S_GTOT: begin
        add_a = tot_r;
        add_b = lat_r;
      end
      default: add_ci = 1'b0;
    endcase
  end
  assign add_sum = add_a + add_b + {63'd0, add_ci};

  assign g_we     = (state_r == S_GTOT);
  assign g_wr_ent = '{id: group_r, cnt: cnt_r, tot: add_sum};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      s_idx_r     <= '0;
      g_valid_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          s_idx_r <= s_idx_r + 1'b1;
          if (s_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r          <= in_command;
            now_r          <= in_now_ns;
            group_r        <= in_task_group;
            tpid_r         <= in_task_pid;
            tpid_start_r   <= in_task_start;
            status_r       <= STS_NONE;
            dropped_r      <= 1'b0;
            lat_r          <= '0;
            cnt_r          <= '0;
            tot_r          <= '0;
            s_idx_r        <= '0;
            s_hit_r        <= 1'b0;
            s_free_found_r <= 1'b0;
            g_idx_r        <= '0;
            g_free_found_r <= 1'b0;
            find_after_r   <= 1'b0;
            find_phase_r   <= 1'b0;
            key_pid_r      <= in_task_pid;
            key_start_r    <= in_task_start;
            case (in_command)
              CMD_WAKE: state_r <= S_SRD;
              CMD_SWITCH: begin
                state_r <= S_SRD;
                if (in_prev_runnable) begin
                  key_pid_r    <= in_prev_pid;
                  key_start_r  <= in_prev_start;
                  find_after_r <= 1'b1;
                end else begin
                  find_phase_r <= 1'b1;
                end
              end
              CMD_QUERY: begin
                state_r  <= S_GRD;
                status_r <= STS_QUERY;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_SRD: state_r <= S_SCK;
        S_SCK: begin
          if (s_match) begin
            s_hit_r     <= 1'b1;
            s_hit_idx_r <= s_idx_r;
            stamp_r     <= s_ent.stamp;
            state_r     <= find_phase_r ? S_LAT : S_SWR;
          end else begin
            if (!s_ent.vld && !s_free_found_r) begin
              s_free_found_r <= 1'b1;
              s_free_idx_r   <= s_idx_r;
            end
            if (s_last) begin
              state_r <= find_phase_r ? S_OUT : S_SWR;
            end else begin
              s_idx_r <= s_idx_r + 1'b1;
              state_r <= S_SRD;
            end
          end
        end
        S_SWR: begin
          if (!(s_hit_r || s_free_found_r)) begin
            dropped_r <= 1'b1;
          end
          if (find_after_r) begin
            key_pid_r      <= tpid_r;
            key_start_r    <= tpid_start_r;
            s_idx_r        <= '0;
            s_hit_r        <= 1'b0;
            s_free_found_r <= 1'b0;
            find_after_r   <= 1'b0;
            find_phase_r   <= 1'b1;
            state_r        <= S_SRD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_LAT: begin
          // The entry is freed in this cycle; the delta comes from the adder.
          lat_r   <= add_sum;
          state_r <= S_GRD;
        end
        S_GRD: state_r <= S_GCK;
        S_GCK: begin
          if (g_match) begin
            g_sel_r <= g_idx_r;
            cnt_r   <= g_ent.cnt;
            tot_r   <= g_ent.tot;
            state_r <= (cmd_r == CMD_QUERY) ? S_OUT : S_GCNT;
          end else begin
            if (!g_valid_r[g_idx_r] && !g_free_found_r) begin
              g_free_found_r <= 1'b1;
              g_free_idx_r   <= g_idx_r;
            end
            if (g_last) begin
              if (cmd_r == CMD_QUERY) begin
                state_r <= S_OUT;
              end else if (g_free_found_r || !g_valid_r[g_idx_r]) begin
                // New group: sums start from zero in the lowest free slot.
                g_sel_r <= g_free_found_r ? g_free_idx_r : g_idx_r;
                state_r <= S_GCNT;
              end else begin
                status_r <= STS_GFULL;
                state_r  <= S_OUT;
              end
            end else begin
              g_idx_r <= g_idx_r + 1'b1;
              state_r <= S_GRD;
            end
          end
        end
        S_GCNT: begin
          cnt_r   <= add_sum;
          state_r <= S_GTOT;
        end
        S_GTOT: begin
          tot_r              <= add_sum;
          g_valid_r[g_sel_r] <= 1'b1;
          status_r           <= STS_ACC;
          state_r            <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_insert_dropped = dropped_r;
  assign out_latency_ns     = lat_r;
  assign out_group_count    = cnt_r;
  assign out_group_total_ns = tot_r;

  `WGLT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not raise busy")
  `WGLT_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy, "result strobe while busy")
  `WGLT_ASSERT_NOW(a_none_zero, clk, rst_n, out_valid && (out_status == STS_NONE), (out_latency_ns == 64'd0) && (out_group_count == 64'd0), "miss result carries data")
endmodule
`default_nettype wire

[tb/per_group_wait_latency_tracker_core_tb.sv]
// Self-checking testbench for per_group_wait_latency_tracker_core.
// Needs wglt_pkg and the tracker RTL; predicts every result from its own table copies.
`default_nettype none
module per_group_wait_latency_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wglt_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] now;
    logic [21:0] pid;
    logic [63:0] tstart;
    logic [63:0] grp;
    logic [21:0] ppid;
    logic [63:0] pstart;
    logic        prun;
  } request_t;

  typedef struct {
    status_t     status;
    logic        dropped;
    logic [63:0] latency;
    logic [63:0] count;
    logic [63:0] total;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [63:0] in_now_ns = '0, in_task_start = '0, in_task_group = '0, in_prev_start = '0;
  logic [21:0] in_task_pid = '0, in_prev_pid = '0;
  logic in_prev_runnable = 1'b0;
  logic out_valid, out_insert_dropped;
  logic [1:0] out_status;
  logic [63:0] out_latency_ns, out_group_count, out_group_total_ns;

  per_group_wait_latency_tracker_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copies of both tables.
  bit          wait_vld [START_ENTRIES];
  logic [21:0] wait_pid [START_ENTRIES];
  logic [63:0] wait_cre [START_ENTRIES];
  logic [63:0] wait_stamp [START_ENTRIES];
  bit          grp_vld [GROUP_ENTRIES];
  logic [63:0] grp_id [GROUP_ENTRIES];
  logic [63:0] grp_cnt [GROUP_ENTRIES];
  logic [63:0] grp_tot [GROUP_ENTRIES];

  outcome_t pending_outcomes[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  logic [63:0] clock_ns = 64'd1000;

  function automatic int wait_find(logic [21:0] pid, logic [63:0] cre);
    for (int i = 0; i < START_ENTRIES; i++)
      if (wait_vld[i] && wait_pid[i] == pid && wait_cre[i] == cre) return i;
    return -1;
  endfunction

  function automatic int wait_used();
    int n;
    n = 0;
    for (int i = 0; i < START_ENTRIES; i++) n += wait_vld[i];
    return n;
  endfunction

  function automatic int grp_used();
    int n;
    n = 0;
    for (int i = 0; i < GROUP_ENTRIES; i++) n += grp_vld[i];
    return n;
  endfunction

  // Returns 1 when the stamp is dropped for lack of a free slot.
  function automatic bit wait_stamp_put(logic [21:0] pid, logic [63:0] cre, logic [63:0] now);
    int i;
    i = wait_find(pid, cre);
    if (i < 0) begin
      for (i = 0; i < START_ENTRIES; i++) if (!wait_vld[i]) break;
      if (i >= START_ENTRIES) return 1'b1;
      wait_vld[i] = 1'b1;
      wait_pid[i] = pid;
      wait_cre[i] = cre;
    end
    wait_stamp[i] = now;
    return 1'b0;
  endfunction

  function automatic int grp_find(logic [63:0] id);
    for (int i = 0; i < GROUP_ENTRIES; i++)
      if (grp_vld[i] && grp_id[i] == id) return i;
    return -1;
  endfunction

  function automatic outcome_t track_latency(request_t r);
    outcome_t o;
    int s, g;
    o = '{STS_NONE, 1'b0, 64'd0, 64'd0, 64'd0};
    if (r.cmd == CMD_WAKE) begin
      o.dropped = wait_stamp_put(r.pid, r.tstart, r.now);
    end else if (r.cmd == CMD_SWITCH) begin
      if (r.prun) o.dropped = wait_stamp_put(r.ppid, r.pstart, r.now);
      s = wait_find(r.pid, r.tstart);
      if (s >= 0) begin
        o.latency = r.now - wait_stamp[s];
        wait_vld[s] = 1'b0;
        g = grp_find(r.grp);
        if (g < 0) begin
          for (g = 0; g < GROUP_ENTRIES; g++) if (!grp_vld[g]) break;
          if (g < GROUP_ENTRIES) begin
            grp_vld[g] = 1'b1;
            grp_id[g] = r.grp;
            grp_cnt[g] = '0;
            grp_tot[g] = '0;
          end else begin
            g = -1;
          end
        end
        if (g >= 0) begin
          grp_cnt[g] += 64'd1;
          grp_tot[g] += o.latency;
          o.count = grp_cnt[g];
          o.total = grp_tot[g];
          o.status = STS_ACC;
        end else begin
          o.status = STS_GFULL;
        end
      end
    end else if (r.cmd == CMD_QUERY) begin
      o.status = STS_QUERY;
      g = grp_find(r.grp);
      if (g >= 0) begin
        o.count = grp_cnt[g];
        o.total = grp_tot[g];
      end
    end
    return o;
  endfunction

  function automatic request_t mk(logic [1:0] cmd, logic [63:0] now, logic [21:0] pid,
                                  logic [63:0] tstart, logic [63:0] grp, logic [21:0] ppid,
                                  logic [63:0] pstart, logic prun);
    request_t r;
    r = '{cmd, now, pid, tstart, grp, ppid, pstart, prun};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Drives one request and holds it until the block takes it.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= r.cmd;
    in_now_ns <= r.now;
    in_task_pid <= r.pid;
    in_task_start <= r.tstart;
    in_task_group <= r.grp;
    in_prev_pid <= r.ppid;
    in_prev_start <= r.pstart;
    in_prev_runnable <= r.prun;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(track_latency(r));
    sent++;
  endtask

  function automatic logic [63:0] tick();
    clock_ns += 64'($urandom_range(5000, 1));
    return clock_ns;
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      received++;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_outcomes.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status); errors++;
        end
        if (out_insert_dropped !== e.dropped) begin
          $error("insert_dropped: expected %0d, got %0d", e.dropped, out_insert_dropped);
          errors++;
        end
        if (out_latency_ns !== e.latency) begin
          $error("latency_ns: expected %0h, got %0h", e.latency, out_latency_ns); errors++;
        end
        if (out_group_count !== e.count) begin
          $error("group_count: expected %0h, got %0h", e.count, out_group_count); errors++;
        end
        if (out_group_total_ns !== e.total) begin
          $error("group_total_ns: expected %0h, got %0h", e.total, out_group_total_ns);
          errors++;
        end
      end
    end
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("per_group_wait_latency_tracker_core_tb: errors");
      $finish;
    end
  end

  task automatic test_directed();
    logic [63:0] mx;
    mx = '1;
    send_request(mk(CMD_QUERY, 0, 0, 0, 64'd5, 0, 0, 0));             // absent group
    send_request(mk(CMD_SWITCH, 10, 22'h3FFFFF, mx, mx, 0, 0, 0));    // miss
    send_request(mk(CMD_WAKE, mx - 64'd5, 22'h3FFFFF, mx, 0, 0, 0, 0));
    send_request(mk(CMD_WAKE, 64'd100, 22'd0, 64'd0, 0, 0, 0, 0));
    send_request(mk(CMD_WAKE, 64'd150, 22'd0, 64'd0, 0, 0, 0, 0));   // overwrite in place
    send_request(mk(CMD_SWITCH, 64'd400, 22'd0, 64'd0, mx, 0, 0, 0));
    // Wrapping delta: current time below the stored stamp.
    send_request(mk(CMD_SWITCH, 64'd20, 22'h3FFFFF, mx, mx, 22'h3FFFFF, mx, 1'b0));
    send_request(mk(CMD_QUERY, 0, 22'h3FFFFF, mx, mx, 22'h3FFFFF, mx, 1'b1));
    // Outgoing key equals incoming key: restamped then found with zero delta.
    send_request(mk(CMD_SWITCH, 64'd900, 22'd7, 64'd3, 64'd0, 22'd7, 64'd3, 1'b1));
    send_request(mk(CMD_SWITCH, 64'd950, 22'd7, 64'd3, 64'd0, 22'd8, 64'd4, 1'b1));
    send_request(mk(CMD_SWITCH, 64'd990, 22'd8, 64'd4, 64'd0, 22'd7, 64'd3, 1'b0));
    send_request(mk(CMD_QUERY, mx, mx[21:0], mx, 64'd0, mx[21:0], mx, 1'b1));
    send_request(mk(CMD_UNUSED, mx, mx[21:0], mx, mx, mx[21:0], mx, 1'b1));
    send_request(mk(CMD_SWITCH, 64'd1000, 22'd7, 64'd3, 64'd0, 0, 0, 0)); // freed key misses
  endtask

  task automatic test_random(int n);
    request_t r;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      r = mk(CMD_WAKE, tick(), 22'($urandom_range(31)), 64'($urandom_range(1)),
             64'($urandom_range(11)), 22'($urandom_range(31)), 64'($urandom_range(1)),
             1'($urandom_range(1)));
      if (pick < 40) r.cmd = CMD_WAKE;
      else if (pick < 80) r.cmd = CMD_SWITCH;
      else if (pick < 95) r.cmd = CMD_QUERY;
      else r.cmd = CMD_UNUSED;
      // Occasional noise over the whole width of the time, pid, start and group fields.
      if ($urandom_range(9) == 0) begin
        r.now = rand64(); r.pid = 22'($urandom); r.tstart = rand64(); r.grp = rand64();
        r.ppid = 22'($urandom); r.pstart = rand64();
      end
      send_request(r);
    end
  endtask

  task automatic test_group_fill();
    int k;
    k = 0;
    while (grp_used() < GROUP_ENTRIES) begin
      send_request(mk(CMD_WAKE, tick(), 22'h200000, 64'hF000, 0, 0, 0, 0));
      send_request(mk(CMD_SWITCH, tick(), 22'h200000, 64'hF000, 64'h5A00_0000 + k,
                      0, 0, 0));
      k++;
    end
    // A measurement for a group that does not fit.
    send_request(mk(CMD_WAKE, tick(), 22'h200001, 64'hF001, 0, 0, 0, 0));
    send_request(mk(CMD_SWITCH, tick(), 22'h200001, 64'hF001, 64'hDEAD_BEEF_0000, 0, 0, 0));
    send_request(mk(CMD_QUERY, 0, 0, 0, 64'h5A00_0000, 0, 0, 0));
  endtask

  task automatic test_start_fill();
    int k;
    k = 0;
    while (wait_used() < START_ENTRIES) begin
      send_request(mk(CMD_WAKE, tick(), 22'h300000 + 22'(k), 64'(k), 0, 0, 0, 0));
      k++;
    end
    send_request(mk(CMD_WAKE, tick(), 22'h3ABCDE, 64'd1, 0, 0, 0, 0));       // dropped
    send_request(mk(CMD_WAKE, tick(), 22'h300000, 64'd0, 0, 0, 0, 0));      // in place
    // Dropped restamp of the outgoing task, then a hit that frees a slot.
    send_request(mk(CMD_SWITCH, tick(), 22'h300001, 64'd1, 64'h5A00_0001,
                    22'h3ABCDE, 64'd2, 1'b1));
    send_request(mk(CMD_WAKE, tick(), 22'h3ABCDE, 64'd1, 0, 0, 0, 0));      // reuses slot
    send_request(mk(CMD_SWITCH, tick(), 22'h3ABCDE, 64'd1, 64'h5A00_0001, 0, 0, 0));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    idle_pct = 0;  test_random(140);
    idle_pct = 88; test_random(140);
    idle_pct = 0;  test_random(140);
    idle_pct = 7;  test_random(130);
    idle_pct = 0;
    test_group_fill();
    test_start_fill();
    @(posedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d requests and %0d results: wakeups, switches, queries,",
             sent, received);
    $display("unused command, wrapping deltas, full group table and full start table.");
    if (errors == 0 && pending_outcomes.size() == 0)
      $display("per_group_wait_latency_tracker_core_tb: clean");
    else
      $display("per_group_wait_latency_tracker_core_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
